FILE: rtl/core/spkt_pkg.sv
// Shared page key table: package with sizes, codes and word types.
// Used by shared_page_key_table_top; depends on nothing.
package spkt_pkg;

  // Table geometry
  localparam int SLOTS      = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int REF_BITS   = 16;

  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int SLOT_OUT_W = 4;

  localparam logic [31:0] USER_TOP_RST = 32'h8000_0000;

  typedef enum logic [0:0] {
    FUNC_GET     = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_NOMEM    = 3'd2,
    STAT_NOKEY    = 3'd3,
    STAT_RESERVED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Request word
  typedef struct packed {
    func_e              func;
    logic signed [31:0] key;
    logic [31:0]        new_frame;
    logic               frame_valid;
  } req_t;

  // Response word
  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [31:0]           map_addr;
    logic [31:0]           frame_addr;
    logic                  zero_frame;
    logic                  free_frame;
  } rsp_t;

  // One slot as held in the table memory
  typedef struct packed {
    logic [31:0]         key;
    logic [31:0]         frame;
    logic [REF_BITS-1:0] refs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/spkt_ram.sv
// Shared page key table: simple dual-port RAM, one write and one read port,
// read data registered. Generic; no package dependency.
module spkt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 80,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/shared_page_key_table_top.sv
// Shared page key table, top level: sequencer, slot table memory and valid bits.
// Depends on spkt_pkg and spkt_ram.
// Sequence: a word accepted while idle is captured, the slot memory is scanned
// through its single read port, one slot a cycle, then ST_DONE updates the table
// and registers the response; busy falls as the response strobe rises. A new word
// is taken only once busy is low. The receiver cannot stall.
// Reset: all slots free at once through per-slot valid bits; user_top = 0x80000000.
module shared_page_key_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spkt_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  output logic          done_o,
  output spkt_pkg::rsp_t rsp_o
);
  import spkt_pkg::*;

  state_e state_q, state_d;
  req_t   item_q;
  logic [31:0] user_top_q;

  // scan control
  logic [CNT_W-1:0]  cnt_q;
  logic              issue;
  logic              rd_pend_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_vld_q;

  // scan results
  logic              hit_q, free_q;
  logic [SLOT_W-1:0] hit_idx_q, free_idx_q;
  logic [31:0]       hit_frame_q;
  logic [REF_BITS-1:0] hit_refs_q;

  // memory
  logic [ENTRY_W-1:0] rdata;
  entry_t             rd_ent, ent;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  entry_t             mem_wdata;
  logic [SLOTS-1:0]   vld_q;
  logic               vld_set, vld_clr;

  // response
  rsp_t rsp_q, rsp_d;
  logic done_q;
  logic [SLOT_W-1:0] sel_idx;
  logic [32:0]       pg_num;
  logic [31:0]       map_off;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  logic accept;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign issue  = (state_q == ST_SCAN) && (cnt_q != CNT_W'(SLOTS));

  spkt_ram #(
    .DEPTH(SLOTS),
    .WIDTH(ENTRY_W),
    .AW   (SLOT_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (issue),
    .raddr_i(cnt_q[SLOT_W-1:0]),
    .rdata_o(rdata)
  );

  // invalid slots read as free (all zero)
  assign rd_ent = entry_t'(rdata);
  assign ent    = rd_vld_q ? rd_ent : '0;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_top_q <= USER_TOP_RST;
    end else if (cfg_we_i) begin
      user_top_q <= cfg_wdata_i;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
    end
  end

  // Scan counter and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_pend_q <= issue;
      if (accept) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q    <= cnt_q + CNT_W'(1);
        rd_idx_q <= cnt_q[SLOT_W-1:0];
        rd_vld_q <= vld_q[cnt_q[SLOT_W-1:0]];
      end
    end
  end

  // First match and first free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (accept) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (rd_pend_q) begin
      if (!hit_q && (ent.key == item_q.key)) begin
        hit_q <= 1'b1;
      end
      if (!free_q && (ent.key == '0)) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q && !hit_q && (ent.key == item_q.key)) begin
      hit_idx_q   <= rd_idx_q;
      hit_frame_q <= ent.frame;
      hit_refs_q  <= ent.refs;
    end
    if (rd_pend_q && !free_q && (ent.key == '0)) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // Valid bits per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (vld_set) begin
      vld_q[mem_waddr] <= 1'b1;
    end else if (vld_clr) begin
      vld_q[mem_waddr] <= 1'b0;
    end
  end

  // Mapping address of the selected slot: the matching slot, else the claimed one
  assign sel_idx  = hit_q ? hit_idx_q : free_idx_q;
  assign pg_num   = 33'(sel_idx) + 33'd1;
  assign map_off  = 32'(pg_num << PAGE_SHIFT);
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, sel_idx};

  // Next state, table update and response
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = hit_idx_q;
    mem_wdata = '0;
    vld_set   = 1'b0;
    vld_clr   = 1'b0;
    rsp_d     = '0;
    rsp_d.status = STAT_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_W'(SLOTS)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
        priority if (item_q.key == '0) begin
          rsp_d.status = STAT_RESERVED;
        end else if (item_q.func == FUNC_GET) begin
          priority if (hit_q) begin
            // attach: count up, saturating
            mem_we          = 1'b1;
            mem_wdata.key   = item_q.key;
            mem_wdata.frame = hit_frame_q;
            mem_wdata.refs  = (hit_refs_q == '1) ? hit_refs_q
                                                 : hit_refs_q + REF_BITS'(1);
            rsp_d.slot       = slot_ext[SLOT_OUT_W-1:0];
            rsp_d.map_addr   = user_top_q - map_off;
            rsp_d.frame_addr = hit_frame_q;
          end else if (!free_q) begin
            rsp_d.status = STAT_FULL;
          end else if (!item_q.frame_valid) begin
            rsp_d.status = STAT_NOMEM;
          end else begin
            // claim the lowest free slot
            mem_waddr       = free_idx_q;
            mem_we          = 1'b1;
            vld_set         = 1'b1;
            mem_wdata.key   = item_q.key;
            mem_wdata.frame = item_q.new_frame;
            mem_wdata.refs  = REF_BITS'(1);
            rsp_d.slot       = slot_ext[SLOT_OUT_W-1:0];
            rsp_d.map_addr   = user_top_q - map_off;
            rsp_d.frame_addr = item_q.new_frame;
            rsp_d.zero_frame = 1'b1;
          end
        end else begin
          priority if (!hit_q) begin
            rsp_d.status = STAT_NOKEY;
          end else begin
            rsp_d.slot       = slot_ext[SLOT_OUT_W-1:0];
            rsp_d.frame_addr = hit_frame_q;
            if (hit_refs_q <= REF_BITS'(1)) begin
              // last reference: slot goes free
              vld_clr          = 1'b1;
              rsp_d.free_frame = 1'b1;
            end else begin
              mem_we          = 1'b1;
              mem_wdata.key   = item_q.key;
              mem_wdata.frame = hit_frame_q;
              mem_wdata.refs  = hit_refs_q - REF_BITS'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Response strobe and word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
